// ===== hw/rtl/fir_linear_convolution_macros.svh =====
// assertion macros for the fir convolution rtl
`ifndef FIR_LINEAR_CONVOLUTION_MACROS_SVH
`define FIR_LINEAR_CONVOLUTION_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold on every rising clock edge
`define FLC_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("fir_linear_convolution: check failed");

// condition that must hold in the cycle after a trigger
`define FLC_ASSERT_NEXT(name, clk, rst_n, trig, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
		else $error("fir_linear_convolution: check failed");

`else

`define FLC_ASSERT(name, clk, rst_n, prop)
`define FLC_ASSERT_NEXT(name, clk, rst_n, trig, prop)

`endif

`endif

// ===== hw/rtl/flc_pkg.sv =====
// types, codes and sizes for the fir convolution block
package flc_pkg;

	localparam int MAX_TAPS = 256;
	localparam int TAP_AW   = $clog2(MAX_TAPS);
	localparam int CNT_W    = TAP_AW + 1;
	localparam int SAMPLE_W = 16;
	localparam int PROD_W   = 2 * SAMPLE_W;
	localparam int ACC_W    = PROD_W + TAP_AW;
	localparam int SHIFT_W  = 5;
	localparam int CFG_DW   = CNT_W;
	localparam int CFG_IW   = 1;

	// action codes
	localparam logic [1:0] ACT_FILTER = 2'd0;
	localparam logic [1:0] ACT_LOAD   = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	// register indexes
	localparam logic [CFG_IW-1:0] REG_TAP_COUNT    = 1'd0;
	localparam logic [CFG_IW-1:0] REG_OUTPUT_SHIFT = 1'd1;

	localparam logic [CNT_W-1:0]   TAP_COUNT_RST    = CNT_W'(1);
	localparam logic [SHIFT_W-1:0] OUTPUT_SHIFT_RST = SHIFT_W'(15);

	typedef struct packed {
		logic [1:0]                 action;
		logic signed [SAMPLE_W-1:0] sample_value;
		logic [TAP_AW-1:0]          tap_index;
		logic signed [SAMPLE_W-1:0] coefficient;
	} req_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filtered_sample;
		logic                       saturated;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_ROUND,
		ST_EMIT
	} state_t;

endpackage

// ===== hw/rtl/fir_linear_convolution.sv =====
// fir convolution block: tap store, sample delay line and one mac
// Streaming direct-form FIR. A load beat writes one tap, a clear beat zeroes the
// delay line, each filter beat pushes a sample and yields one rounded, saturated
// output. Load, clear and unused beats complete on acceptance. A filter beat reads
// the tap and history memories once per tap for the M effective taps (1..256),
// feeding a single multiply-accumulate through a read and a multiply register,
// then a rounding register and a shift and saturate into the result register.
// req_stall is high from acceptance until the result loads; a finished result
// can wait in the output register while the next beat is accepted. No clearing
// pass after reset: history entries older than the fill count since the last
// clear read as zero. Taps must be written before a filter beat uses them.
`include "fir_linear_convolution_macros.svh"

module fir_linear_convolution (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [flc_pkg::CFG_IW-1:0]           cfg_index,
	input  logic [flc_pkg::CFG_DW-1:0]           cfg_data,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  flc_pkg::req_t                        req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output flc_pkg::rsp_t                        rsp
);

	localparam int AW   = flc_pkg::TAP_AW;
	localparam int CW   = flc_pkg::CNT_W;
	localparam int SW   = flc_pkg::SAMPLE_W;
	localparam int PW   = flc_pkg::PROD_W;
	localparam int ACW  = flc_pkg::ACC_W;
	localparam int SHW  = flc_pkg::SHIFT_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(flc_pkg::MAX_TAPS);
	localparam logic signed [ACW-1:0] SAT_HI = ACW'((64'sd1 <<< (SW - 1)) - 64'sd1);
	localparam logic signed [ACW-1:0] SAT_LO = -SAT_HI - ACW'(1);

	// configuration registers
	logic [CW-1:0]  tap_count_q;
	logic [SHW-1:0] output_shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q    <= flc_pkg::TAP_COUNT_RST;
			output_shift_q <= flc_pkg::OUTPUT_SHIFT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				flc_pkg::REG_TAP_COUNT:    tap_count_q    <= cfg_data;
				flc_pkg::REG_OUTPUT_SHIFT: output_shift_q <= cfg_data[SHW-1:0];
				default: ;
			endcase
		end
	end

	flc_pkg::state_t state_q, state_d;
	logic            accept;
	logic            issue;
	logic            do_filter, do_load, do_clear;
	logic            last_issue;
	logic            emit_load;

	logic [AW-1:0]   head_q;
	logic [AW-1:0]   head_next;
	logic [CW-1:0]   fill_q;
	logic [CW-1:0]   tap_eff;
	logic [CW-1:0]   tap_eff_q;
	logic [CW-1:0]   issue_idx_q;
	logic [AW-1:0]   hist_raddr;

	logic                 vld_s1, last_s1, hvalid_s1;
	logic signed [SW-1:0] tap_rd_s1, hist_rd_s1;
	logic                 vld_s2, last_s2;
	logic signed [PW-1:0] prod_s2;

	logic signed [ACW-1:0] acc_q;
	logic signed [ACW-1:0] rnd_q;
	logic signed [ACW-1:0] rnd_add;
	logic signed [ACW-1:0] shifted;
	logic signed [SW-1:0]  sat_val;
	logic                  sat_flag;

	logic                 rsp_valid_q;
	flc_pkg::rsp_t        rsp_q;

	assign accept    = req_valid && !req_stall;
	assign do_filter = accept && (req.action == flc_pkg::ACT_FILTER);
	assign do_load   = accept && (req.action == flc_pkg::ACT_LOAD);
	assign do_clear  = accept && (req.action == flc_pkg::ACT_CLEAR);
	assign head_next = head_q + AW'(1);
	assign last_issue = issue && (issue_idx_q == tap_eff_q - CW'(1));
	assign emit_load  = !rsp_valid_q || !rsp_stall;

	// effective tap count: zero acts as one, above the store depth clips
	always_comb begin
		if (tap_count_q == '0) begin
			tap_eff = CW'(1);
		end else if (tap_count_q > MAX_CNT) begin
			tap_eff = MAX_CNT;
		end else begin
			tap_eff = tap_count_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			flc_pkg::ST_IDLE: begin
				if (do_filter) state_d = flc_pkg::ST_RUN;
			end
			flc_pkg::ST_RUN: begin
				if (last_issue) state_d = flc_pkg::ST_DRAIN;
			end
			flc_pkg::ST_DRAIN: begin
				if (last_s2) state_d = flc_pkg::ST_ROUND;
			end
			flc_pkg::ST_ROUND: begin
				state_d = flc_pkg::ST_EMIT;
			end
			flc_pkg::ST_EMIT: begin
				if (emit_load) state_d = flc_pkg::ST_IDLE;
			end
			default: state_d = flc_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		req_stall = 1'b1;
		issue     = 1'b0;
		case (state_q)
			flc_pkg::ST_IDLE: req_stall = 1'b0;
			flc_pkg::ST_RUN:  issue     = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// delay line head and fill count since the last clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (do_clear) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (do_filter) begin
			head_q <= head_next;
			if (fill_q != MAX_CNT) fill_q <= fill_q + CW'(1);
		end
	end

	// tap walk counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_idx_q <= '0;
			tap_eff_q   <= CW'(1);
		end else if (do_filter) begin
			issue_idx_q <= '0;
			tap_eff_q   <= tap_eff;
		end else if (issue) begin
			issue_idx_q <= issue_idx_q + CW'(1);
		end
	end

	assign hist_raddr = head_q - issue_idx_q[AW-1:0];

	// tap store memory
	logic signed [SW-1:0] tap_mem [flc_pkg::MAX_TAPS];

	always_ff @(posedge clk) begin
		if (do_load) tap_mem[req.tap_index] <= req.coefficient;
		if (issue) tap_rd_s1 <= tap_mem[issue_idx_q[AW-1:0]];
	end

	// sample history memory
	logic signed [SW-1:0] hist_mem [flc_pkg::MAX_TAPS];

	always_ff @(posedge clk) begin
		if (do_filter) hist_mem[head_next] <= req.sample_value;
		if (issue) hist_rd_s1 <= hist_mem[hist_raddr];
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			last_s1   <= 1'b0;
			hvalid_s1 <= 1'b0;
		end else begin
			vld_s1    <= issue;
			last_s1   <= last_issue;
			hvalid_s1 <= issue_idx_q < fill_q;
		end
	end

	// multiply stage; history beyond the fill count reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) prod_s2 <= hvalid_s1 ? (tap_rd_s1 * hist_rd_s1) : PW'(0);
	end

	// accumulate, then add the rounding constant
	assign rnd_add = (output_shift_q == '0) ? '0
		: (ACW'(1) << (output_shift_q - SHW'(1)));

	always_ff @(posedge clk) begin
		if (do_filter) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + {{(ACW-PW){prod_s2[PW-1]}}, prod_s2};
		end
		if (state_q == flc_pkg::ST_ROUND) rnd_q <= acc_q + rnd_add;
	end

	// shift and saturate
	assign shifted = rnd_q >>> output_shift_q;

	always_comb begin
		sat_flag = 1'b0;
		if (shifted > SAT_HI) begin
			sat_val  = SAT_HI[SW-1:0];
			sat_flag = 1'b1;
		end else if (shifted < SAT_LO) begin
			sat_val  = SAT_LO[SW-1:0];
			sat_flag = 1'b1;
		end else begin
			sat_val = shifted[SW-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == flc_pkg::ST_EMIT && emit_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == flc_pkg::ST_EMIT && emit_load) begin
			rsp_q.filtered_sample <= sat_val;
			rsp_q.saturated       <= sat_flag;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	`FLC_ASSERT(a_issue_in_range, clk, arst_n, !issue || (issue_idx_q < tap_eff_q))
	`FLC_ASSERT(a_fill_bounded, clk, arst_n, fill_q <= MAX_CNT)
	`FLC_ASSERT(a_last_in_drain, clk, arst_n, !last_s2 || (state_q == flc_pkg::ST_DRAIN))
	`FLC_ASSERT_NEXT(a_filter_starts, clk, arst_n, do_filter, state_q == flc_pkg::ST_RUN)
	`FLC_ASSERT_NEXT(a_emit_loads, clk, arst_n, (state_q == flc_pkg::ST_EMIT) && emit_load, rsp_valid_q)

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the fir convolution block: directed table, then random phases
module testbench;
	import flc_pkg::*;

	localparam logic [1:0] ACT_UNUSED    = 2'd3;
	localparam int         CYCLE_LIMIT   = 500000;
	localparam int         SETTLE_CYCLES = 8;
	localparam int         DRAIN_CYCLES  = MAX_TAPS + 16;
	localparam int         NUM_PHASES    = 10;
	localparam int         MAX_REPORTS   = 100;

	typedef struct {
		req_t beat;
		bit   typed;
		rsp_t want;
	} script_row_t;

	logic          clk;
	logic          arst_n    = 1'b0;
	logic          cfg_we    = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data  = '0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	req_t          req       = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	rsp_t          rsp;

	fir_linear_convolution dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// filter state mirrored by the testbench
	logic signed [SAMPLE_W-1:0] coef_store   [MAX_TAPS];
	bit                         coef_written [MAX_TAPS];
	logic signed [SAMPLE_W-1:0] delay_line   [MAX_TAPS];
	logic [TAP_AW-1:0]          newest        = '0;
	logic [CFG_DW-1:0]          tap_count_reg = TAP_COUNT_RST;
	logic [SHIFT_W-1:0]         shift_amt     = OUTPUT_SHIFT_RST;

	rsp_t        expected_outputs [$];
	script_row_t script [$];
	rsp_t        head_want;

	int src_idle_pct    = 0;
	int sink_stall_pct  = 0;
	int mismatches      = 0;
	int outputs_checked = 0;
	int cycle_count     = 0;
	int beats_by_action [4];

	// register settings per random phase; the widest tap counts get few beats
	int phase_taps  [NUM_PHASES] = '{1, 0, 4, 16, 511, 3, 256, 33, 2, 100};
	int phase_shift [NUM_PHASES] = '{15, 0, 31, 16, 24, 1, 31, 17, 14, 18};
	int phase_beats [NUM_PHASES] = '{100, 80, 90, 100, 25, 100, 15, 100, 100, 60};

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// tap count zero acts as one, counts past the store clamp to its size
	function automatic int effective_taps();
		if (tap_count_reg == '0)
			return 1;
		if (tap_count_reg > CFG_DW'(MAX_TAPS))
			return MAX_TAPS;
		return int'(tap_count_reg);
	endfunction

	// sample or tap value, biased toward the extremes
	function automatic logic [SAMPLE_W-1:0] pick_word();
		case ($urandom_range(11))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hffff;
			4: return 16'h0001;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic req_t random_beat();
		req_t b;
		int   pick;
		b.sample_value = pick_word();
		b.tap_index    = TAP_AW'($urandom);
		b.coefficient  = pick_word();
		pick = $urandom_range(99);
		if (pick < 64)
			b.action = ACT_FILTER;
		else if (pick < 84)
			b.action = ACT_LOAD;
		else if (pick < 90)
			b.action = ACT_CLEAR;
		else
			b.action = ACT_UNUSED;
		return b;
	endfunction

	// advance the mirrored filter by one beat, giving the output it yields
	task automatic convolve_beat(input req_t beat, output bit yields, output rsp_t out);
		longint            acc;
		longint            val;
		longint            hi;
		int                taps;
		int                k;
		logic [TAP_AW-1:0] slot;
		yields = 1'b0;
		out    = '0;
		hi     = (longint'(1) << (SAMPLE_W - 1)) - 1;
		case (beat.action)
			ACT_LOAD: begin
				coef_store[beat.tap_index]   = beat.coefficient;
				coef_written[beat.tap_index] = 1'b1;
			end
			ACT_CLEAR: begin
				foreach (delay_line[i])
					delay_line[i] = '0;
				newest = '0;
			end
			ACT_FILTER: begin
				newest             = newest + 1'b1;
				delay_line[newest] = beat.sample_value;
				taps = effective_taps();
				acc  = 0;
				slot = newest;
				for (k = 0; k < taps; k++) begin
					acc += longint'(coef_store[k]) * longint'(delay_line[slot]);
					slot = slot - 1'b1;
				end
				// round half up, then floor shift
				if (shift_amt != '0)
					acc += longint'(1) << (shift_amt - 1'b1);
				val = acc >>> shift_amt;
				if (val > hi) begin
					val           = hi;
					out.saturated = 1'b1;
				end else if (val < -hi - 1) begin
					val           = -hi - 1;
					out.saturated = 1'b1;
				end
				out.filtered_sample = SAMPLE_W'(val);
				yields = 1'b1;
			end
			default: ;
		endcase
	endtask

	task automatic add_row(input logic [1:0] action, input logic [SAMPLE_W-1:0] sample,
			input logic [TAP_AW-1:0] index, input logic [SAMPLE_W-1:0] coef,
			input bit typed, input logic [SAMPLE_W-1:0] want_sample, input bit want_sat);
		script_row_t r;
		r.beat.action         = action;
		r.beat.sample_value   = sample;
		r.beat.tap_index      = index;
		r.beat.coefficient    = coef;
		r.typed               = typed;
		r.want.filtered_sample = want_sample;
		r.want.saturated      = want_sat;
		script.push_back(r);
	endtask

	// drive one request beat and hold it until accepted
	task automatic send_beat(input req_t beat, input bit typed, input rsp_t want);
		bit   yields;
		rsp_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= beat;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		convolve_beat(beat, yields, predicted);
		beats_by_action[beat.action]++;
		if (yields)
			expected_outputs.push_back(typed ? want : predicted);
	endtask

	// let the block drain before touching its registers
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (expected_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] index, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= CFG_DW'(value);
		if (index == REG_TAP_COUNT)
			tap_count_reg = CFG_DW'(value);
		else
			shift_amt = SHIFT_W'(value);
		@(posedge clk);
	endtask

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	// output side stalls
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	// compare each output beat with the oldest pending prediction
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_outputs.size() == 0) begin
				report_mismatch("output beat with no filter beat pending");
			end else begin
				head_want = expected_outputs.pop_front();
				outputs_checked++;
				if (rsp.filtered_sample !== head_want.filtered_sample)
					report_mismatch($sformatf("filtered_sample got %0d want %0d",
						$signed(rsp.filtered_sample), $signed(head_want.filtered_sample)));
				if (rsp.saturated !== head_want.saturated)
					report_mismatch($sformatf("saturated got %b want %b",
						rsp.saturated, head_want.saturated));
			end
		end
	end

	// cycle limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("cycle limit reached, %0d outputs outstanding", expected_outputs.size());
		$display("== FAIL ==");
		$finish;
	end

	// stimulus
	initial begin
		req_t b;
		int   p;
		int   i;
		foreach (delay_line[k]) begin
			delay_line[k]   = '0;
			coef_store[k]   = '0;
			coef_written[k] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at reset settings: one tap, shift 15
		// action, sample, index, coefficient, typed, want sample, want saturated
		add_row(ACT_LOAD,   16'h0000, 8'h00, 16'h7fff, 1'b0, '0, 1'b0); // largest tap
		add_row(ACT_FILTER, 16'h7fff, 8'h00, 16'h0000, 1'b0, '0, 1'b0);
		add_row(ACT_FILTER, 16'h8000, 8'hff, 16'hffff, 1'b0, '0, 1'b0);
		add_row(ACT_FILTER, 16'h0000, 8'h3c, 16'h1234, 1'b1, 16'h0000, 1'b0);
		add_row(ACT_LOAD,   16'hffff, 8'h00, 16'h8000, 1'b0, '0, 1'b0); // most negative tap
		add_row(ACT_FILTER, 16'h8000, 8'h00, 16'h0000, 1'b1, 16'h7fff, 1'b1); // clips high
		add_row(ACT_FILTER, 16'h7fff, 8'h00, 16'h0000, 1'b0, '0, 1'b0);
		add_row(ACT_FILTER, 16'h0001, 8'h00, 16'h0000, 1'b0, '0, 1'b0);
		add_row(ACT_FILTER, 16'hffff, 8'h00, 16'h0000, 1'b0, '0, 1'b0);
		add_row(ACT_CLEAR,  16'h5a5a, 8'ha5, 16'h5a5a, 1'b0, '0, 1'b0);
		add_row(ACT_FILTER, 16'h0000, 8'h00, 16'h0000, 1'b1, 16'h0000, 1'b0);
		add_row(ACT_UNUSED, 16'hffff, 8'hff, 16'hffff, 1'b0, '0, 1'b0); // ignored code
		add_row(ACT_LOAD,   16'h0000, 8'h00, 16'h4000, 1'b0, '0, 1'b0);
		add_row(ACT_FILTER, 16'h0001, 8'h00, 16'h0000, 1'b0, '0, 1'b0); // half rounds up
		add_row(ACT_FILTER, 16'hffff, 8'h00, 16'h0000, 1'b0, '0, 1'b0); // negative half
		add_row(ACT_LOAD,   16'h1234, 8'hff, 16'h5555, 1'b0, '0, 1'b0); // top tap slot
		add_row(ACT_LOAD,   16'hedcb, 8'h80, 16'haaaa, 1'b0, '0, 1'b0);
		add_row(ACT_FILTER, 16'h7fff, 8'h00, 16'h0000, 1'b0, '0, 1'b0);
		add_row(ACT_UNUSED, 16'h0000, 8'h00, 16'h0000, 1'b0, '0, 1'b0);
		add_row(ACT_CLEAR,  16'hffff, 8'hff, 16'hffff, 1'b0, '0, 1'b0);
		add_row(ACT_FILTER, 16'h8000, 8'h00, 16'h0000, 1'b0, '0, 1'b0);
		foreach (script[r])
			send_beat(script[r].beat, script[r].typed, script[r].want);

		// random phases, each under its own settings and idling mix
		for (p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			write_reg(REG_TAP_COUNT, phase_taps[p]);
			write_reg(REG_OUTPUT_SHIFT, phase_shift[p]);
			cfg_we <= 1'b0;
			case (p % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 52; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 52; end
				default: begin src_idle_pct = 9; sink_stall_pct = 9; end
			endcase
			// every tap in use gets a value before a filter beat reads it
			for (i = 0; i < effective_taps(); i++) begin
				if (!coef_written[i]) begin
					b              = random_beat();
					b.action       = ACT_LOAD;
					b.tap_index    = TAP_AW'(i);
					send_beat(b, 1'b0, '0);
				end
			end
			repeat (phase_beats[p]) send_beat(random_beat(), 1'b0, '0);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("beats accepted: %0d filter, %0d tap load, %0d clear, %0d unused code",
			beats_by_action[ACT_FILTER], beats_by_action[ACT_LOAD],
			beats_by_action[ACT_CLEAR], beats_by_action[ACT_UNUSED]);
		$display("%0d filter outputs checked across %0d register settings, %0d mismatches",
			outputs_checked, NUM_PHASES + 1, mismatches);
		if (mismatches == 0 && expected_outputs.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/flc_pkg.sv
hw/rtl/fir_linear_convolution.sv
dv/testbench.sv
